@@ sv/wav_riff_header_parser_core_macros.svh @@
// assertion macros for the wav header parser
`ifndef WAV_RIFF_HEADER_PARSER_CORE_MACROS_SVH
`define WAV_RIFF_HEADER_PARSER_CORE_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define WRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/wrp_pkg.sv @@
// shared types and constants of the wav header parser
`timescale 1ns / 1ps
package wrp_pkg;
    localparam int unsigned FILE_SIZE_W = 32;
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned OUT_TDATA_W = 200;
    localparam logic [PADDR_W-1:0] ADDR_FILE_SIZE = 3'd0;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] MIN_FILE_SIZE = 32'd12;
    localparam logic [4:0] MUL_LAST = 5'd15;
    localparam logic [4:0] MOD_LAST = 5'd31;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_FORMAT  = 2'd2,
        STAT_UNSUPP  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHUNK_HDR,
        PH_FMT,
        PH_SKIP,
        PH_MUL,
        PH_MOD,
        PH_DONE
    } phase_t;

    typedef enum logic {
        OP_MUL,
        OP_MOD
    } alu_op_t;

    typedef struct packed {
        logic    go;
        alu_op_t op;
    } alu_cmd_t;

    typedef struct packed {
        logic        done;
        logic [47:0] prod;
        logic [15:0] rem;
    } alu_res_t;
endpackage

@@ sv/wrp_alu.sv @@
// iterative shift-add multiplier and restoring remainder unit
`timescale 1ns / 1ps
module wrp_alu (
    input  logic             aclk,
    input  logic             aresetn,
    input  wrp_pkg::alu_cmd_t cmd,
    input  logic [31:0]      opa,
    input  logic [15:0]      opb,
    output wrp_pkg::alu_res_t res
);
    import wrp_pkg::*;

    alu_op_t     op_reg, op_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [47:0] acc_reg, acc_next;
    logic [47:0] a_reg, a_next;
    logic [15:0] b_reg, b_next;
    logic [16:0] trial;
    logic [4:0]  last;

    assign trial = {acc_reg[15:0], a_reg[31]};
    assign last  = (op_reg == OP_MUL) ? MUL_LAST : MOD_LAST;

    always_comb begin
        op_next   = op_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (cmd.go) begin
            op_next  = cmd.op;
            run_next = 1'b1;
            cnt_next = '0;
            acc_next = '0;
            a_next   = {16'd0, opa};
            b_next   = opb;
        end else if (run_reg) begin
            if (op_reg == OP_MUL) begin
                if (b_reg[0]) begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = {a_reg[46:0], 1'b0};
                b_next = {1'b0, b_reg[15:1]};
            end else begin
                if (trial >= {1'b0, b_reg}) begin
                    acc_next = {31'd0, trial - {1'b0, b_reg}};
                end else begin
                    acc_next = {31'd0, trial};
                end
                a_next = {a_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == last) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign res.done = done_reg;
    assign res.prod = acc_reg;
    assign res.rem  = acc_reg[15:0];
endmodule

@@ sv/wav_riff_header_parser_core.sv @@
// wav riff header parser top level: byte walker, checks and result register
// timing: the result is registered and valid the cycle after the deciding byte; a last
//   fmt byte first waits for the 16-step multiply and a data header for the 32-step remainder
// throughput: 1 byte per cycle, except in those stalls and while a result waits on m_tready
// reset: synchronous active-low aresetn clears parser state and file_size
`timescale 1ns / 1ps
`include "wav_riff_header_parser_core_macros.svh"
module wav_riff_header_parser_core #(
    parameter int unsigned PADDR_WIDTH = wrp_pkg::PADDR_W
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // data_byte
    input  logic                     s_tuser,   // file_start
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // status, fmt_tag, chan_cnt, frame_rate, bytes_per_sec, frame_bytes,
    // sample_bits, payload_offset, payload_len, zero pad
    output logic [wrp_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_WIDTH-1:0]   paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import wrp_pkg::*;

    logic [31:0]      file_size_reg;
    phase_t           phase_reg, phase_next;
    logic [31:0]      pos_reg, pos_next;
    logic [31:0]      limit_reg, limit_next;
    logic [3:0]       fs_reg, fs_next;
    logic [31:0]      tag_reg, tag_next;
    logic [31:0]      len_reg, len_next;
    logic [31:0]      nxt_reg, nxt_next;
    logic [15:0][7:0] fmt_reg, fmt_next;
    logic             seen_reg, seen_next;

    logic             m_tvalid_reg;
    status_t          st_reg, st_sel;
    logic [127:0]     fmtout_reg;
    logic [31:0]      doff_reg, dsize_reg, doff_sel, dsize_sel;
    logic             emit;

    logic             s_acc;
    alu_cmd_t         u_cmd;
    alu_res_t         u_res;
    logic [31:0]      u_a;
    logic [15:0]      u_b;

    logic [31:0]      c_pos, c_limit, c_tag, c_len, c_nxt;
    logic [3:0]       c_fs;
    phase_t           c_phase;
    logic [2:0]       k3;
    logic [32:0]      poff, room, padded;
    logic [15:0]      f_fmt, f_ch, f_ba, f_bits;
    logic [18:0]      expect_ba;
    logic [31:0]      lane;

    function automatic logic chunk_fail(input logic [31:0] off, input logic [31:0] lim);
        chunk_fail = (off >= lim) || ((lim - off) < 32'd8);
    endfunction

    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_FILE_SIZE) ? file_size_reg : 32'd0;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, dsize_reg, doff_reg, fmtout_reg, st_reg};

    assign f_fmt  = {fmt_next[1], fmt_next[0]};
    assign f_ch   = {fmt_next[3], fmt_next[2]};
    assign f_ba   = {fmt_next[13], fmt_next[12]};
    assign f_bits = {fmt_next[15], fmt_next[14]};
    assign expect_ba = {3'd0, f_ch} * {16'd0, f_bits[5:3]};

    // next state
    always_comb begin
        c_pos   = s_tuser ? 32'd0 : pos_reg;
        c_limit = s_tuser ? 32'd0 : limit_reg;
        c_tag   = s_tuser ? 32'd0 : tag_reg;
        c_len   = s_tuser ? 32'd0 : len_reg;
        c_nxt   = s_tuser ? 32'd0 : nxt_reg;
        c_fs    = s_tuser ? 4'd0 : fs_reg;
        c_phase = s_tuser ? PH_HEADER : phase_reg;
        k3      = c_fs[2:0];
        lane    = {24'd0, s_tdata};
        poff    = {1'b0, c_pos} + 33'd1;
        room    = {1'b0, c_limit} - poff;
        padded  = '0;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        limit_next = limit_reg;
        fs_next    = fs_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        nxt_next   = nxt_reg;
        fmt_next   = fmt_reg;
        seen_next  = seen_reg;
        emit       = 1'b0;
        st_sel     = STAT_FORMAT;
        doff_sel   = '0;
        dsize_sel  = '0;
        u_cmd.go   = 1'b0;
        u_cmd.op   = OP_MUL;
        u_a        = {fmt_next[7], fmt_next[6], fmt_next[5], fmt_next[4]};
        u_b        = f_ba;
        if (phase_reg == PH_MUL) begin
            if (u_res.done) begin
                if (u_res.prod[47:32] != 16'd0 ||
                    u_res.prod[31:0] != {fmt_reg[11], fmt_reg[10], fmt_reg[9], fmt_reg[8]}) begin
                    emit = 1'b1;
                end else begin
                    seen_next  = 1'b1;
                    phase_next = PH_SKIP;
                    if (nxt_reg == pos_reg) begin
                        if (chunk_fail(nxt_reg, limit_reg)) begin
                            emit = 1'b1;
                        end else begin
                            phase_next = PH_CHUNK_HDR;
                            fs_next = '0;
                            tag_next = '0;
                            len_next = '0;
                        end
                    end
                end
            end
        end else if (phase_reg == PH_MOD) begin
            if (u_res.done) begin
                emit = 1'b1;
                if (u_res.rem == 16'd0) begin
                    st_sel    = STAT_OK;
                    doff_sel  = pos_reg;
                    dsize_sel = len_reg;
                end
            end
        end else if (s_acc) begin
            pos_next   = c_pos + 32'd1;
            limit_next = c_limit;
            tag_next   = c_tag;
            len_next   = c_len;
            nxt_next   = c_nxt;
            fs_next    = c_fs;
            phase_next = c_phase;
            if (s_tuser) begin
                fmt_next  = '0;
                seen_next = 1'b0;
            end
            case (c_phase)
                PH_HEADER: begin
                    if (c_pos[3:2] == 2'd1) begin
                        len_next = c_len | (lane << {c_pos[1:0], 3'b000});
                    end else begin
                        tag_next = c_tag | (lane << {c_pos[1:0], 3'b000});
                    end
                    if (c_pos == 32'd0 && file_size_reg < MIN_FILE_SIZE) begin
                        emit   = 1'b1;
                        st_sel = STAT_INVALID;
                    end else if (c_pos == 32'd3) begin
                        if (tag_next != TAG_RIFF) emit = 1'b1;
                        tag_next = '0;
                    end else if (c_pos == 32'd7) begin
                        if ({1'b0, len_next} + 33'd8 > {1'b0, file_size_reg}) emit = 1'b1;
                        limit_next = len_next + 32'd8;
                    end else if (c_pos == 32'd11) begin
                        if (tag_next != TAG_WAVE || chunk_fail(MIN_FILE_SIZE, c_limit)) begin
                            emit = 1'b1;
                        end else begin
                            phase_next = PH_CHUNK_HDR;
                            fs_next = '0;
                            tag_next = '0;
                            len_next = '0;
                        end
                    end
                end
                PH_CHUNK_HDR: begin
                    fs_next = {1'b0, k3} + 4'd1;
                    if (!k3[2]) begin
                        tag_next = c_tag | (lane << {k3[1:0], 3'b000});
                    end else begin
                        len_next = c_len | (lane << {k3[1:0], 3'b000});
                    end
                    padded = {1'b0, len_next} + {32'd0, len_next[0]};
                    if (k3 == 3'd7) begin
                        nxt_next = poff[31:0] + padded[31:0];
                        if (poff > {1'b0, c_limit} || padded > room) begin
                            emit = 1'b1;
                        end else if (tag_next == TAG_FMT) begin
                            if (len_next < 32'd16) begin
                                emit = 1'b1;
                            end else begin
                                phase_next = PH_FMT;
                                fs_next = '0;
                            end
                        end else if (tag_next == TAG_DATA) begin
                            if (!seen_reg || f_ba == 16'd0 || s_tuser) begin
                                emit = 1'b1;
                            end else begin
                                phase_next = PH_MOD;
                                u_cmd.go = 1'b1;
                                u_cmd.op = OP_MOD;
                                u_a = len_next;
                            end
                        end else begin
                            phase_next = PH_SKIP;
                            if (nxt_next == pos_next) begin
                                if (chunk_fail(nxt_next, c_limit)) begin
                                    emit = 1'b1;
                                end else begin
                                    phase_next = PH_CHUNK_HDR;
                                    fs_next = '0;
                                    tag_next = '0;
                                    len_next = '0;
                                end
                            end
                        end
                    end
                end
                PH_FMT: begin
                    fmt_next[c_fs] = s_tdata;
                    fs_next = c_fs + 4'd1;
                    if (c_fs == 4'd15) begin
                        if (f_fmt != 16'd1 || f_ch == 16'd0 ||
                            (f_bits != 16'd8 && f_bits != 16'd16 &&
                             f_bits != 16'd24 && f_bits != 16'd32)) begin
                            emit   = 1'b1;
                            st_sel = STAT_UNSUPP;
                        end else if (expect_ba[18:16] != 3'd0 || f_ba != expect_ba[15:0]) begin
                            emit = 1'b1;
                        end else begin
                            phase_next = PH_MUL;
                            u_cmd.go = 1'b1;
                        end
                    end
                end
                PH_SKIP: begin
                    if (c_nxt == pos_next) begin
                        if (chunk_fail(c_nxt, c_limit)) begin
                            emit = 1'b1;
                        end else begin
                            phase_next = PH_CHUNK_HDR;
                            fs_next = '0;
                            tag_next = '0;
                            len_next = '0;
                        end
                    end
                end
                default: begin
                    phase_next = c_phase;
                end
            endcase
        end
        if (emit) phase_next = PH_DONE;
    end

    // handshake outputs
    always_comb begin
        case (phase_reg)
            PH_MUL, PH_MOD: s_tready = 1'b0;
            default:        s_tready = !m_tvalid_reg || m_tready;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_size_reg <= '0;
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            limit_reg     <= '0;
            fs_reg        <= '0;
            tag_reg       <= '0;
            len_reg       <= '0;
            nxt_reg       <= '0;
            fmt_reg       <= '0;
            seen_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_FILE_SIZE) begin
                file_size_reg <= pwdata;
            end
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            limit_reg    <= limit_next;
            fs_reg       <= fs_next;
            tag_reg      <= tag_next;
            len_reg      <= len_next;
            nxt_reg      <= nxt_next;
            fmt_reg      <= fmt_next;
            seen_reg     <= seen_next;
            m_tvalid_reg <= emit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
        end
        if (emit) begin
            st_reg     <= st_sel;
            fmtout_reg <= fmt_next;
            doff_reg   <= doff_sel;
            dsize_reg  <= dsize_sel;
        end
    end

    wrp_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (u_cmd),
        .opa     (u_a),
        .opb     (u_b),
        .res     (u_res)
    );

    `WRP_ASSERT_NOW(a_busy_stall, (phase_reg == PH_MUL || phase_reg == PH_MOD), !s_tready, "input taken while unit busy")
    `WRP_ASSERT_NOW(a_done_phase, u_res.done, (phase_reg == PH_MUL || phase_reg == PH_MOD), "unit result outside a check")
    `WRP_ASSERT_NOW(a_emit_done, $rose(m_tvalid_reg), (phase_reg == PH_DONE), "result without finished parse")
    `WRP_ASSERT_NEXT(a_start_unit, u_cmd.go, (phase_reg == PH_MUL || phase_reg == PH_MOD), "unit started outside a check")
endmodule

@@ sim/wav_riff_header_parser_core_tb.sv @@
// self-checking testbench for the wav riff header parser: byte streams in, header results checked
`timescale 1ns / 1ps
module wav_riff_header_parser_core_tb;
    import wrp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [31:0] TAG_LIST = 32'h5453_494C;

    typedef struct {
        status_t     st;
        logic [15:0] fmt_tag;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [31:0] brate;
        logic [15:0] balign;
        logic [15:0] bits;
        logic [31:0] doff;
        logic [31:0] dsize;
    } wav_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;   // data_byte
    logic                   s_tuser;   // file_start
    logic                   m_tvalid;
    logic                   m_tready;
    // status, fmt_tag, chan_cnt, frame_rate, bytes_per_sec, frame_bytes,
    // sample_bits, payload_offset, payload_len, zero pad
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    wav_riff_header_parser_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    wav_result_t header_results[$];
    logic [7:0]  wav_bytes[$];
    logic [31:0] wav_riff;
    int          errors = 0;
    int          sent_bytes = 0;
    int unsigned cycles = 0;
    bit          steady = 0;

    // parser shadow state
    logic [31:0] cfg_file_size;
    logic [31:0] pos_q;
    logic [31:0] riff_lim;
    phase_t      phase;
    logic [31:0] fshift;
    logic [31:0] tag_acc;
    logic [31:0] len_acc;
    logic [31:0] next_start;
    logic [7:0]  fmt_b[16];
    bit          fmt_ok;
    bit          finished;

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [15:0] fmt16(int k);
        return {fmt_b[4'(k + 1)], fmt_b[4'(k)]};
    endfunction

    function automatic logic [31:0] fmt32(int k);
        return {fmt16(k + 2), fmt16(k)};
    endfunction

    function automatic void restart_parse();
        pos_q = 0;
        riff_lim = 0;
        phase = PH_HEADER;
        fshift = 0;
        tag_acc = 0;
        len_acc = 0;
        next_start = 0;
        foreach (fmt_b[i]) fmt_b[i] = 8'h00;
        fmt_ok = 0;
        finished = 0;
    endfunction

    function automatic void push_result(status_t st, logic [31:0] doff, logic [31:0] dsize);
        wav_result_t r;
        r.st = st;
        r.fmt_tag = fmt16(0);
        r.chans = fmt16(2);
        r.rate = fmt32(4);
        r.brate = fmt32(8);
        r.balign = fmt16(12);
        r.bits = fmt16(14);
        r.doff = doff;
        r.dsize = dsize;
        header_results.push_back(r);
        finished = 1;
    endfunction

    function automatic void start_chunk(logic [31:0] off);
        if (off >= riff_lim || (riff_lim - off) < 8) begin
            push_result(STAT_FORMAT, 0, 0);
        end else begin
            phase = PH_CHUNK_HDR;
            fshift = 0;
            tag_acc = 0;
            len_acc = 0;
        end
    endfunction

    function automatic void wav_step(logic [7:0] b, bit st);
        logic [31:0] p;
        logic [31:0] k;
        logic [31:0] ba;
        logic [31:0] want;
        logic [31:0] rate;
        logic [31:0] bits;
        logic [63:0] poff;
        logic [63:0] padded;
        logic [31:0] wide;
        if (st) restart_parse();
        if (finished) return;
        p = pos_q;
        pos_q = p + 1;
        wide = {24'h0, b};
        case (phase)
            PH_HEADER: begin
                if (p == 0 && cfg_file_size < MIN_FILE_SIZE) begin
                    push_result(STAT_INVALID, 0, 0);
                    return;
                end
                if (p < 4 || p >= 8) tag_acc |= wide << (8 * p[1:0]);
                else len_acc |= wide << (8 * p[1:0]);
                if (p == 3) begin
                    if (tag_acc != TAG_RIFF) push_result(STAT_FORMAT, 0, 0);
                    else tag_acc = 0;
                end else if (p == 7) begin
                    if ({32'h0, len_acc} + 64'd8 > {32'h0, cfg_file_size})
                        push_result(STAT_FORMAT, 0, 0);
                    else riff_lim = len_acc + 8;
                end else if (p == 11) begin
                    if (tag_acc != TAG_WAVE) push_result(STAT_FORMAT, 0, 0);
                    else start_chunk(12);
                end
            end
            PH_CHUNK_HDR: begin
                k = fshift & 7;
                fshift = k + 1;
                if (k < 4) tag_acc |= wide << (8 * k);
                else len_acc |= wide << (8 * (k - 4));
                if (k != 7) return;
                poff = {32'h0, p} + 64'd1;
                if (poff > {32'h0, riff_lim} || {32'h0, len_acc} > {32'h0, riff_lim} - poff) begin
                    push_result(STAT_FORMAT, 0, 0);
                    return;
                end
                padded = {32'h0, len_acc} + {63'h0, len_acc[0]};
                if (padded > {32'h0, riff_lim} - poff) begin
                    push_result(STAT_FORMAT, 0, 0);
                    return;
                end
                next_start = 32'(poff + padded);
                if (tag_acc == TAG_FMT) begin
                    if (len_acc < 16) push_result(STAT_FORMAT, 0, 0);
                    else begin
                        phase = PH_FMT;
                        fshift = 0;
                    end
                end else if (tag_acc == TAG_DATA) begin
                    ba = {16'h0, fmt16(12)};
                    if (!fmt_ok || ba == 0 || (len_acc % ba) != 0) push_result(STAT_FORMAT, 0, 0);
                    else push_result(STAT_OK, 32'(poff), len_acc);
                end else begin
                    phase = PH_SKIP;
                    if (next_start == p + 1) start_chunk(next_start);
                end
            end
            PH_FMT: begin
                k = fshift & 15;
                fmt_b[k[3:0]] = b;
                fshift = k + 1;
                if (fshift < 16) return;
                bits = {16'h0, fmt16(14)};
                rate = fmt32(4);
                ba = {16'h0, fmt16(12)};
                if (fmt16(0) != 16'd1 || fmt16(2) == 0 ||
                    (bits != 8 && bits != 16 && bits != 24 && bits != 32)) begin
                    push_result(STAT_UNSUPP, 0, 0);
                    return;
                end
                want = {16'h0, fmt16(2)} * bits / 8;
                if (want == 0 || want > 32'hFFFF || ba != want ||
                    rate > (32'hFFFF_FFFF / ba) || fmt32(8) != rate * ba) begin
                    push_result(STAT_FORMAT, 0, 0);
                    return;
                end
                fmt_ok = 1;
                phase = PH_SKIP;
                if (next_start == p + 1) start_chunk(next_start);
            end
            PH_SKIP: begin
                if (next_start == p + 1) start_chunk(next_start);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        wav_result_t r;
        if (aresetn && m_tvalid && m_tready) begin
            if (header_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
                errors++;
            end else begin
                r = header_results.pop_front();
                check_field("status", 32'(r.st), 32'(m_tdata[1:0]));
                check_field("fmt_tag", 32'(r.fmt_tag), 32'(m_tdata[17:2]));
                check_field("chan_cnt", 32'(r.chans), 32'(m_tdata[33:18]));
                check_field("frame_rate", r.rate, m_tdata[65:34]);
                check_field("bytes_per_sec", r.brate, m_tdata[97:66]);
                check_field("frame_bytes", 32'(r.balign), 32'(m_tdata[113:98]));
                check_field("sample_bits", 32'(r.bits), 32'(m_tdata[129:114]));
                check_field("payload_offset", r.doff, m_tdata[161:130]);
                check_field("payload_len", r.dsize, m_tdata[193:162]);
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 8);
    end

    task automatic send_byte(input logic [7:0] b, input bit st);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 8) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tdata = b;
        s_tuser = st;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        wav_step(b, st);
        sent_bytes++;
    endtask

    task automatic send_wav(input int count, input bit with_start);
        for (int i = 0; i < count && i < wav_bytes.size(); i++)
            send_byte(wav_bytes[i], with_start && i == 0);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 0;
        while (header_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_file_size(input logic [31:0] v);
        @(negedge aclk);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = ADDR_FILE_SIZE;
        pwdata = v;
        @(negedge aclk);
        penable = 1;
        @(negedge aclk);
        pwrite = 0;
        penable = 0;
        @(negedge aclk);
        penable = 1;
        @(posedge aclk);
        if (prdata !== v) begin
            $display("%0t: file_size readback mismatch, expected %h actual %h", $time, v, prdata);
            errors++;
        end
        @(negedge aclk);
        psel = 0;
        penable = 0;
        cfg_file_size = v;
    endtask

    function automatic void put32(logic [31:0] v);
        for (int i = 0; i < 4; i++) wav_bytes.push_back(v[8*i+:8]);
    endfunction

    function automatic void put16(logic [15:0] v);
        wav_bytes.push_back(v[7:0]);
        wav_bytes.push_back(v[15:8]);
    endfunction

    function automatic void put_noise(int n);
        for (int i = 0; i < n; i++) wav_bytes.push_back(8'($urandom));
    endfunction

    function automatic void build_wav(logic [15:0] ftag, logic [15:0] chans, logic [31:0] rate,
                                      logic [31:0] brate, logic [15:0] balign, logic [15:0] bits,
                                      int fmt_len, int junk_len, logic [31:0] data_len,
                                      bit data_first, int trail);
        wav_bytes.delete();
        wav_riff = 4 + 8 + fmt_len + (fmt_len & 1) + 8 + data_len + data_len[0];
        if (junk_len >= 0) wav_riff += 8 + junk_len + (junk_len & 1);
        put32(TAG_RIFF);
        put32(wav_riff);
        put32(TAG_WAVE);
        if (junk_len >= 0) begin
            put32(TAG_LIST);
            put32(junk_len);
            put_noise(junk_len + (junk_len & 1));
        end
        if (data_first) begin
            put32(TAG_DATA);
            put32(data_len);
        end
        put32(TAG_FMT);
        put32(fmt_len);
        put16(ftag);
        put16(chans);
        put32(rate);
        put32(brate);
        put16(balign);
        put16(bits);
        if (fmt_len > 16) put_noise(fmt_len - 16 + (fmt_len & 1));
        put32(TAG_DATA);
        put32(data_len);
        put_noise(trail);
    endfunction

    function automatic void build_pcm(logic [15:0] chans, logic [15:0] bits, logic [31:0] rate,
                                      int junk_len, int frames);
        logic [15:0] ba;
        ba = 16'(chans * bits / 8);
        build_wav(16'd1, chans, rate, rate * ba, ba, bits, 16, junk_len, ba * frames, 0, 2);
    endfunction

    function automatic void build_random_pcm();
        logic [15:0] bits;
        logic [15:0] chans;
        logic [15:0] ftag;
        logic [15:0] ba;
        logic [31:0] rate;
        int          fmt_len;
        int          junk_len;
        bits = 16'(8 * $urandom_range(1, 4));
        chans = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
        rate = ($urandom_range(9) == 0) ? $urandom : $urandom_range(8000, 192000);
        ftag = ($urandom_range(19) == 0) ? 16'($urandom) : 16'd1;
        ba = 16'(chans * bits / 8);
        fmt_len = ($urandom_range(3) == 0) ? 16 + $urandom_range(1, 5) : 16;
        junk_len = ($urandom_range(2) == 0) ? $urandom_range(0, 9) : -1;
        build_wav(ftag, chans, rate, rate * ba, ba, bits, fmt_len, junk_len,
                  ba * $urandom_range(0, 40), $urandom_range(19) == 0, $urandom_range(0, 3));
    endfunction

    task automatic test_headless_start();
        build_pcm(16'd2, 16'd16, 32'd44100, -1, 3);
        set_file_size(32'hFFFF_FFFF);
        send_wav(wav_bytes.size(), 0);
        wait_drained();
    endtask

    task automatic test_short_file();
        set_file_size(32'd0);
        send_byte(8'h52, 1);
        wait_drained();
        set_file_size(32'd11);
        send_byte(8'hFF, 1);
        wait_drained();
        set_file_size(32'd12);
        wav_bytes.delete();
        put32(TAG_RIFF);
        put32(32'd4);
        put32(TAG_WAVE);
        send_wav(wav_bytes.size(), 1);
        wait_drained();
    endtask

    task automatic test_header_errors();
        build_pcm(16'd1, 16'd8, 32'd8000, -1, 5);
        set_file_size(wav_riff + 8);
        send_wav(wav_bytes.size(), 1);
        wait_drained();
        set_file_size(wav_riff + 7);
        send_wav(wav_bytes.size(), 1);
        wait_drained();
        set_file_size(32'hFFFF_FFFF);
        wav_bytes[0] = 8'h00;
        send_wav(wav_bytes.size(), 1);
        build_pcm(16'd1, 16'd8, 32'd8000, -1, 5);
        wav_bytes[9] = 8'h00;
        send_wav(wav_bytes.size(), 1);
        build_pcm(16'd1, 16'd8, 32'd8000, -1, 5);
        wav_bytes[4] = 8'hFF;
        wav_bytes[5] = 8'hFF;
        wav_bytes[6] = 8'hFF;
        wav_bytes[7] = 8'hFF;
        send_wav(wav_bytes.size(), 1);
        wait_drained();
    endtask

    task automatic test_format_checks();
        build_wav(16'd3, 16'd2, 32'd48000, 32'd384000, 16'd8, 16'd32, 16, -1, 32'd8, 0, 1);
        send_wav(wav_bytes.size(), 1);
        build_wav(16'd1, 16'd0, 32'd48000, 32'd0, 16'd0, 16'd16, 16, -1, 32'd0, 0, 1);
        send_wav(wav_bytes.size(), 1);
        build_wav(16'd1, 16'd1, 32'd48000, 32'd96000, 16'd2, 16'd12, 16, -1, 32'd2, 0, 1);
        send_wav(wav_bytes.size(), 1);
        build_wav(16'd1, 16'd2, 32'd48000, 32'd192000, 16'd3, 16'd16, 16, -1, 32'd4, 0, 1);
        send_wav(wav_bytes.size(), 1);
        // rate times block align overflows 32 bits
        build_wav(16'd1, 16'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFC, 16'd4, 16'd16, 16, -1, 32'd4, 0, 1);
        send_wav(wav_bytes.size(), 1);
        build_wav(16'd1, 16'd2, 32'd48000, 32'd192001, 16'd4, 16'd16, 16, -1, 32'd4, 0, 1);
        send_wav(wav_bytes.size(), 1);
        build_wav(16'd1, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8, 14, -1, 32'd4, 0, 1);
        send_wav(wav_bytes.size(), 1);
        build_wav(16'd1, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8, 19, 5, 32'd7, 0, 3);
        send_wav(wav_bytes.size(), 1);
        build_wav(16'd1, 16'd2, 32'd8000, 32'd16000, 16'd2, 16'd8, 16, -1, 32'd8, 1, 1);
        send_wav(wav_bytes.size(), 1);
        build_wav(16'd1, 16'd3, 32'd8000, 32'd72000, 16'd9, 16'd24, 16, 0, 32'd10, 0, 1);
        send_wav(wav_bytes.size(), 1);
        // restart in the middle of a file, then bytes after a result
        build_pcm(16'd4, 16'd32, 32'd96000, 2, 1);
        send_wav(20, 1);
        send_wav(wav_bytes.size(), 1);
        wait_drained();
    endtask

    task automatic test_random_files();
        int  n;
        int  cut;
        logic [31:0] fs;
        n = 0;
        while (sent_bytes < 1450) begin
            steady = (n >= 2 && n < 6);
            build_random_pcm();
            if ($urandom_range(4) == 0)
                wav_bytes[$urandom_range(0, wav_bytes.size() - 1)] = 8'($urandom);
            if ($urandom_range(5) == 0) begin
                wait_drained();
                case ($urandom_range(3))
                    0: fs = wav_riff + 8;
                    1: fs = wav_riff + 7;
                    2: fs = $urandom;
                    default: fs = 32'hFFFF_FFFF;
                endcase
                set_file_size(fs);
            end
            cut = ($urandom_range(9) == 0) ? $urandom_range(1, wav_bytes.size()) : wav_bytes.size();
            send_wav(cut, 1);
            if (n % 7 == 6) wait_drained();
            n++;
        end
        steady = 0;
        wait_drained();
    endtask

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        m_tready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        cfg_file_size = 0;
        restart_parse();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // first file after reset carries no start flag
        test_headless_start();
        test_short_file();
        test_header_errors();
        test_format_checks();
        test_random_files();

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
